FILE: hdl/nfa_pkg.sv
// Shared types and constants for the nfa word acceptor.
// Used by nfa_word_acceptor and nfa_checker; no dependencies.
package nfa_pkg;

   localparam int MASK_W          = 16;
   localparam int STATE_W         = 4;
   localparam int SYM_W           = 8;
   localparam int NUM_STATES_DEF  = 16;
   localparam int SYMBOL_BITS_DEF = 8;

   // request tdata layout, low bit first
   localparam int REQ_FROM_LSB = 0;
   localparam int REQ_SYM_LSB  = REQ_FROM_LSB + STATE_W;
   localparam int REQ_MASK_LSB = REQ_SYM_LSB + SYM_W;
   localparam int REQ_DATA_W   = 32;
   localparam int REQ_USER_W   = 2;

   // response tdata layout, low bit first
   localparam int RSP_ACC_LSB = 0;
   localparam int RSP_SET_LSB = 1;
   localparam int RSP_DATA_W  = 24;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = MASK_W;

   typedef enum logic [REQ_USER_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_SYMBOL = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_MASK = 1'b0,
      CSR_FINAL_MASK = 1'b1
   } csr_index_type;

   // accepted sits in the low bit, active_set above it
   typedef struct packed {
      logic [MASK_W-1:0]  active_set;
      logic               accepted;
   } result_type;

endpackage

FILE: hdl/nfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/nfa_word_acceptor.sv
// Top level of the nfa word acceptor: transition banks, active-set loop, result queue.
// Depends on nfa_pkg and nfa_ram.
//
// Takes one item per clock while req_tready is high. Loads (kind 0) write one next-state
// mask into the bank of their source state at the symbol address. Word symbols (kind 1)
// read the row of all banks at the symbol address; in the next cycle that row
// is AND-ORed with the active set, which is registered and feeds straight back, so the
// active-set loop through the bank read data sets the rate. A result (last symbol or
// empty-word query) passes the evaluate stage into a four-deep queue and shows on rsp
// from there, so req_tready stays high until four results are held back or pending.
// After reset the transition banks are cleared one symbol address per cycle with
// req_tready low; configuration writes are taken during that pass.
module nfa_word_acceptor #(
   parameter int NUM_STATES  = nfa_pkg::NUM_STATES_DEF,
   parameter int SYMBOL_BITS = nfa_pkg::SYMBOL_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // from_state[3:0], symbol[11:4], next_mask[27:12], zero[31:28]
   input  logic [nfa_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[1:0]
   input  logic [nfa_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // accepted[0], active_set[16:1], zero[23:17]
   output logic [nfa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [nfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nfa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nfa_pkg::*;

   localparam int NUM_ROWS  = (NUM_STATES >= MASK_W) ? MASK_W : NUM_STATES;
   localparam int SYM_DEPTH = 1 << SYMBOL_BITS;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = 2;

   // configuration
   logic [MASK_W-1:0] start_mask_ff, start_mask_in;
   logic [MASK_W-1:0] final_mask_ff, final_mask_in;

   // bank clearing pass
   logic                   clearing_ff, clearing_in;
   logic [SYMBOL_BITS-1:0] clr_addr_ff, clr_addr_in;

   // request decode
   logic                   req_acc;
   kind_type               req_kind;
   logic [STATE_W-1:0]     req_from;
   logic [SYMBOL_BITS-1:0] req_sym;
   logic [NUM_ROWS-1:0]    req_mask;

   // banks
   logic [SYMBOL_BITS-1:0] bank_waddr;
   logic [NUM_ROWS-1:0]    bank_wdata;
   logic [NUM_ROWS-1:0]    bank_rd [NUM_ROWS];

   // evaluate stage
   logic                s1_valid_ff, s1_valid_in;
   kind_type            s1_kind_ff, s1_kind_in;
   logic                s1_last_ff, s1_last_in;
   logic [NUM_ROWS-1:0] active_ff, active_in;
   logic                inside_ff, inside_in;
   logic [NUM_ROWS-1:0] cur_set;
   logic [NUM_ROWS-1:0] step_set;
   logic [NUM_ROWS-1:0] start_cut;
   logic                push;
   result_type          push_res;

   // result queue
   result_type           q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   q_wr_ff, q_wr_in;
   logic [Q_PTR_W-1:0]   q_rd_ff, q_rd_in;
   logic [Q_PTR_W:0]     q_cnt_ff, q_cnt_in;
   logic                 pop;
   logic                 s1_res;
   logic [Q_PTR_W+1:0]   q_claim;

   assign req_kind = kind_type'(req_tuser);
   assign req_from = req_tdata[REQ_FROM_LSB +: STATE_W];
   assign req_sym  = req_tdata[REQ_SYM_LSB +: SYMBOL_BITS];
   assign req_mask = req_tdata[REQ_MASK_LSB +: NUM_ROWS];

   // a result of the item in the evaluate stage still has to land in the queue
   assign s1_res  = s1_valid_ff && ((s1_kind_ff == KIND_EMPTY) || s1_last_ff);
   assign q_claim = (Q_PTR_W+2)'(q_cnt_ff) + (Q_PTR_W+2)'(s1_res);

   assign req_tready = !clearing_ff && (q_claim < (Q_PTR_W+2)'(Q_DEPTH));
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      start_mask_in = start_mask_ff;
      final_mask_in = final_mask_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_MASK: start_mask_in = csr_wdata;
            CSR_FINAL_MASK: final_mask_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (&clr_addr_ff) begin
            clearing_in = 1'b0;
         end
      end
   end

   assign bank_waddr = clearing_ff ? clr_addr_ff : req_sym;
   assign bank_wdata = clearing_ff ? '0 : req_mask;

   for (genvar i = 0; i < NUM_ROWS; i++) begin : g_bank
      logic bank_we;
      assign bank_we = clearing_ff ||
                       (req_acc && (req_kind == KIND_LOAD) && (req_from == STATE_W'(i)));
      nfa_ram #(
         .WIDTH (NUM_ROWS),
         .DEPTH (SYM_DEPTH)
      ) u_bank (
         .clock (clock),
         .we    (bank_we),
         .waddr (bank_waddr),
         .wdata (bank_wdata),
         .re    (req_acc),
         .raddr (req_sym),
         .rdata (bank_rd[i])
      );
   end

   always_comb begin
      s1_valid_in = req_acc && ((req_kind == KIND_SYMBOL) || (req_kind == KIND_EMPTY));
      s1_kind_in  = req_kind;
      s1_last_in  = req_tlast;
   end

   assign start_cut = start_mask_ff[NUM_ROWS-1:0];
   assign cur_set   = inside_ff ? active_ff : start_cut;

   always_comb begin
      step_set = '0;
      for (int s = 0; s < NUM_ROWS; s++) begin
         if (cur_set[s]) begin
            step_set = step_set | bank_rd[s];
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      inside_in = inside_ff;
      push      = 1'b0;
      push_res.active_set = MASK_W'(step_set);
      push_res.accepted   = |(step_set & final_mask_ff[NUM_ROWS-1:0]);
      if (s1_valid_ff) begin
         case (s1_kind_ff)
            KIND_SYMBOL: begin
               active_in = step_set;
               inside_in = !s1_last_ff;
               push      = s1_last_ff;
            end
            KIND_EMPTY: begin
               active_in = start_cut;
               inside_in = 1'b0;
               push      = 1'b1;
               push_res.active_set = MASK_W'(start_cut);
               push_res.accepted   = |(start_cut & final_mask_ff[NUM_ROWS-1:0]);
            end
            default: ;
         endcase
      end
   end

   assign pop = rsp_tvalid && rsp_tready;

   always_comb begin
      q_wr_in  = q_wr_ff + Q_PTR_W'(push);
      q_rd_in  = q_rd_ff + Q_PTR_W'(pop);
      q_cnt_in = q_cnt_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_mask_ff <= MASK_W'(1);
         final_mask_ff <= '0;
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         active_ff     <= '0;
         inside_ff     <= 1'b0;
         q_wr_ff       <= '0;
         q_rd_ff       <= '0;
         q_cnt_ff      <= '0;
      end else begin
         start_mask_ff <= start_mask_in;
         final_mask_ff <= final_mask_in;
         clearing_ff   <= clearing_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         active_ff     <= active_in;
         inside_ff     <= inside_in;
         q_wr_ff       <= q_wr_in;
         q_rd_ff       <= q_rd_in;
         q_cnt_ff      <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= s1_kind_in;
      s1_last_ff <= s1_last_in;
      if (push) begin
         q_ff[q_wr_ff] <= push_res;
      end
   end

   assign rsp_tvalid = (q_cnt_ff != '0);
   assign rsp_tdata  = RSP_DATA_W'(q_ff[q_rd_ff]);

endmodule

FILE: hdl/nfa_checker.sv
// Port-level checks for nfa_word_acceptor, attached by bind.
// Depends on nfa_pkg.
module nfa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [nfa_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [nfa_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [nfa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            csr_we,
   input logic [nfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [nfa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nfa_pkg::*;

   logic req_end;
   assign req_end = req_tvalid && req_tready &&
                    ((req_tuser == KIND_EMPTY) || ((req_tuser == KIND_SYMBOL) && req_tlast));

   // banks are being cleared right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high in the first cycle after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // an empty queue fills only from a word end or empty query that went through the evaluate stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_end, 2))
      else $error("response without a matching item");

endmodule

bind nfa_word_acceptor nfa_checker u_nfa_checker (.*);
